// ===== src/usd_pkg.sv =====
// ----------------------------------------------------------------------------
// usd_pkg
// shared widths, constants and the sequence assembly function of the
// byte-serial utf-8 decoder
// ----------------------------------------------------------------------------
package usd_pkg;

   localparam int BYTE_W        = 8;
   localparam int CODE_POINT_W  = 32;
   localparam int CODE_UNITS_W  = 32;
   localparam int INVALID_CP_W  = 22;
   localparam int HELD_W        = 24;
   localparam int COUNT_W       = 2;
   localparam int CSR_INDEX_W   = 8;
   localparam int CSR_DATA_W    = 32;

   localparam logic [INVALID_CP_W-1:0] INVALID_CP_RESET    = 22'h00FFFD;
   localparam logic [CODE_UNITS_W-1:0] INVALID_UNITS_RESET = 32'h00EFBFBD;

   localparam logic [BYTE_W-1:0] LEAD4_BASE = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD3_BASE = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD2_BASE = 8'hC0;
   localparam logic [BYTE_W-1:0] CONT_BASE  = 8'h80;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_INVALID_CODE_POINT = 8'd0,
      CSR_INVALID_UNITS      = 8'd1
   } csr_index_type;

   // build the code point of a finished sequence; seen is the byte count
   // held before the last continuation (1, 2 or 3)
   function automatic logic [INVALID_CP_W-1:0] assemble(
      input logic [CODE_UNITS_W-1:0] units,
      input logic [COUNT_W-1:0]      seen
   );
      logic [BYTE_W-1:0] b3, b2, b1, b0;
      logic [31:0]       cp;
      b3 = units[31:24];
      b2 = units[23:16];
      b1 = units[15:8];
      b0 = units[7:0];
      case (seen)
         2'd3: begin
            cp = ({24'd0, b3 - LEAD4_BASE} << 18) | ({24'd0, b2 - CONT_BASE} << 12)
               | ({24'd0, b1 - CONT_BASE} << 6) | {24'd0, b0 - CONT_BASE};
         end
         2'd2: begin
            cp = ({24'd0, b2 - LEAD3_BASE} << 12) | ({24'd0, b1 - CONT_BASE} << 6)
               | {24'd0, b0 - CONT_BASE};
         end
         default: begin
            cp = ({24'd0, b1 - LEAD2_BASE} << 6) | {24'd0, b0 - CONT_BASE};
         end
      endcase
      return cp[INVALID_CP_W-1:0];
   endfunction

endpackage

// ===== src/utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// byte-serial utf-8 decoder: one byte per request, code points out
// ----------------------------------------------------------------------------
// timing: a byte is registered at acceptance and decoded into the result
//   register once the result side is free or the byte gives no result
// throughput: one byte per cycle while req_stall is low; a byte that breaks
//   an open sequence and is itself a character gives two results and holds
//   the input until the second result has moved on to the result register
// reset: synchronous, active high; clears the open sequence and both channels,
//   error marker registers return to U+FFFD and its utf-8 bytes
module utf8_stream_decoder (
   input  logic                              clock,
   input  logic                              reset,
   // byte requests
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [usd_pkg::BYTE_W-1:0]        req_byte_in,
   // decoded results
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [usd_pkg::CODE_POINT_W-1:0]  rsp_code_point,
   output logic [usd_pkg::CODE_UNITS_W-1:0]  rsp_code_units,
   output logic                              rsp_error,
   output logic                              rsp_last_of_run,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [usd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [usd_pkg::CSR_DATA_W-1:0]    csr_data
);
   import usd_pkg::*;

   // error marker registers
   logic [INVALID_CP_W-1:0] inv_cp_ff,    inv_cp_in;
   logic [CODE_UNITS_W-1:0] inv_units_ff, inv_units_in;

   // input register
   logic                    in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]       in_byte_ff,  in_byte_in;

   // open sequence state
   logic [HELD_W-1:0]       held_ff,   held_in;
   logic [COUNT_W-1:0]      needed_ff, needed_in;
   logic [COUNT_W-1:0]      seen_ff,   seen_in;

   // result register and the spare slot for a second result
   logic                    rsp_valid_ff,  rsp_valid_in;
   logic [CODE_POINT_W-1:0] rsp_cp_ff,     rsp_cp_in;
   logic [CODE_UNITS_W-1:0] rsp_units_ff,  rsp_units_in;
   logic                    rsp_error_ff,  rsp_error_in;
   logic                    rsp_last_ff,   rsp_last_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [BYTE_W-1:0]       pend_byte_ff,  pend_byte_in;

   // decode of the registered byte
   logic [CODE_UNITS_W-1:0] units;
   logic [1:0]              dec_count;
   logic [CODE_POINT_W-1:0] dec_cp;
   logic [CODE_UNITS_W-1:0] dec_units;
   logic                    dec_error;
   logic                    dec_last;
   logic                    dec_second;
   logic [HELD_W-1:0]       dec_held;
   logic [COUNT_W-1:0]      dec_needed;
   logic [COUNT_W-1:0]      dec_seen;

   logic                    out_free;
   logic                    go;
   logic                    req_take;

   // registers are always writable; writes must come only while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   always_comb begin
      inv_cp_in    = inv_cp_ff;
      inv_units_in = inv_units_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_INVALID_CODE_POINT: inv_cp_in    = csr_data[INVALID_CP_W-1:0];
            CSR_INVALID_UNITS:      inv_units_in = csr_data[CODE_UNITS_W-1:0];
            default:                ;
         endcase
      end
   end

   // one decode step per byte: at most one result to the result register
   // and, for a character that breaks a sequence, one to the spare slot
   always_comb begin
      units      = {held_ff, in_byte_ff};
      dec_count  = 2'd0;
      dec_cp     = {{(CODE_POINT_W-BYTE_W){1'b0}}, in_byte_ff};
      dec_units  = {{(CODE_UNITS_W-BYTE_W){1'b0}}, in_byte_ff};
      dec_error  = 1'b0;
      dec_last   = 1'b1;
      dec_second = 1'b0;
      dec_held   = held_ff;
      dec_needed = needed_ff;
      dec_seen   = seen_ff;
      if (needed_ff != '0 && in_byte_ff[BYTE_W-1]) begin
         // continuation byte
         if (needed_ff == 2'd1) begin
            dec_count  = 2'd1;
            dec_cp     = {{(CODE_POINT_W-INVALID_CP_W){1'b0}}, assemble(units, seen_ff)};
            dec_units  = units;
            dec_held   = '0;
            dec_needed = '0;
            dec_seen   = '0;
         end else begin
            dec_held   = units[HELD_W-1:0];
            dec_needed = needed_ff - 2'd1;
            dec_seen   = seen_ff + 2'd1;
         end
      end else if (needed_ff != '0) begin
         // sequence broken by a plain byte: error, then the byte as a lead
         dec_count  = (in_byte_ff == '0) ? 2'd1 : 2'd2;
         dec_second = (in_byte_ff != '0);
         dec_cp     = {{(CODE_POINT_W-INVALID_CP_W){1'b0}}, inv_cp_ff};
         dec_units  = inv_units_ff;
         dec_error  = 1'b1;
         dec_last   = (in_byte_ff == '0);
         dec_held   = '0;
         dec_needed = '0;
         dec_seen   = '0;
      end else if (in_byte_ff == '0) begin
         // end of string with nothing open: no result
         dec_count = 2'd0;
      end else if (!in_byte_ff[BYTE_W-1]) begin
         // single byte character
         dec_count = 2'd1;
      end else if (in_byte_ff < LEAD2_BASE) begin
         // stray continuation
         dec_count = 2'd1;
         dec_cp    = {{(CODE_POINT_W-INVALID_CP_W){1'b0}}, inv_cp_ff};
         dec_units = inv_units_ff;
         dec_error = 1'b1;
      end else begin
         // lead byte opens a sequence
         dec_held = {{(HELD_W-BYTE_W){1'b0}}, in_byte_ff};
         dec_seen = 2'd1;
         if (in_byte_ff >= LEAD4_BASE) begin
            dec_needed = 2'd3;
         end else if (in_byte_ff >= LEAD3_BASE) begin
            dec_needed = 2'd2;
         end else begin
            dec_needed = 2'd1;
         end
      end
   end

   // the result register frees when empty or when its result is taken;
   // a byte without results never waits on the result side
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign go        = in_valid_ff && ((dec_count == 2'd0) || (out_free && !pend_valid_ff));
   assign req_stall = in_valid_ff && !go;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_byte_in;
      end else if (go) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      held_in   = held_ff;
      needed_in = needed_ff;
      seen_in   = seen_ff;
      if (go) begin
         held_in   = dec_held;
         needed_in = dec_needed;
         seen_in   = dec_seen;
      end
   end

   // result register loads the spare slot first, else the fresh decode
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_cp_in     = rsp_cp_ff;
      rsp_units_in  = rsp_units_ff;
      rsp_error_in  = rsp_error_ff;
      rsp_last_in   = rsp_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_byte_in  = pend_byte_ff;
      if (out_free) begin
         if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_cp_in     = {{(CODE_POINT_W-BYTE_W){1'b0}}, pend_byte_ff};
            rsp_units_in  = {{(CODE_UNITS_W-BYTE_W){1'b0}}, pend_byte_ff};
            rsp_error_in  = 1'b0;
            rsp_last_in   = 1'b1;
            pend_valid_in = 1'b0;
         end else begin
            rsp_valid_in  = go && (dec_count != 2'd0);
            rsp_cp_in     = dec_cp;
            rsp_units_in  = dec_units;
            rsp_error_in  = dec_error;
            rsp_last_in   = dec_last;
            pend_valid_in = go && dec_second;
            pend_byte_in  = in_byte_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_cp_ff     <= INVALID_CP_RESET;
         inv_units_ff  <= INVALID_UNITS_RESET;
         in_valid_ff   <= 1'b0;
         held_ff       <= '0;
         needed_ff     <= '0;
         seen_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         inv_cp_ff     <= inv_cp_in;
         inv_units_ff  <= inv_units_in;
         in_valid_ff   <= in_valid_in;
         held_ff       <= held_in;
         needed_ff     <= needed_in;
         seen_ff       <= seen_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_byte_ff   <= in_byte_in;
      rsp_cp_ff    <= rsp_cp_in;
      rsp_units_ff <= rsp_units_in;
      rsp_error_ff <= rsp_error_in;
      rsp_last_ff  <= rsp_last_in;
      pend_byte_ff <= pend_byte_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_code_point  = rsp_cp_ff;
   assign rsp_code_units  = rsp_units_ff;
   assign rsp_error       = rsp_error_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

// ===== src/usd_checker.sv =====
// ----------------------------------------------------------------------------
// usd_checker
// port-level checks of the utf-8 decoder, bound into the decoder module
// ----------------------------------------------------------------------------
module usd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [usd_pkg::CODE_POINT_W-1:0]  rsp_code_point,
   input logic [usd_pkg::CODE_UNITS_W-1:0]  rsp_code_units,
   input logic                              rsp_error,
   input logic                              rsp_last_of_run
);
   import usd_pkg::*;

   // a stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_point)
         && $stable(rsp_code_units) && $stable(rsp_error) && $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   // only an error result can be followed by another result of the same byte
   a_ok_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_error |-> rsp_last_of_run)
      else $error("good result not marked last");

   // a single byte character decodes to its own value
   a_single_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_error && rsp_code_units[CODE_UNITS_W-1:BYTE_W] == '0
         |-> rsp_code_point == rsp_code_units)
      else $error("single byte result mismatch");

   // reset empties the result channel
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind utf8_stream_decoder usd_checker chk (.*);

// ===== tb/sv/utf8_decode_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_decode_checker
// watches the byte, result and register channels of the utf-8 decoder,
// predicts every decoded character and compares it field by field
// ----------------------------------------------------------------------------
module utf8_decode_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [usd_pkg::BYTE_W-1:0]        req_byte_in,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [usd_pkg::CODE_POINT_W-1:0]  rsp_code_point,
   input  logic [usd_pkg::CODE_UNITS_W-1:0]  rsp_code_units,
   input  logic                              rsp_error,
   input  logic                              rsp_last_of_run,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [usd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [usd_pkg::CSR_DATA_W-1:0]    csr_data,
   output int                                failures,
   output int                                pending
);
   import usd_pkg::*;

   localparam int PRINT_LIMIT = 50;

   typedef struct packed {
      logic [CODE_POINT_W-1:0] code_point;
      logic [CODE_UNITS_W-1:0] code_units;
      logic                    error;
      logic                    last_of_run;
   } decoded_char_type;

   decoded_char_type          expected_chars[$];

   // decoder state as predicted
   logic [HELD_W-1:0]         held;
   logic [COUNT_W-1:0]        open_needed;
   logic [COUNT_W-1:0]        open_seen;
   logic [INVALID_CP_W-1:0]   marker_cp;
   logic [CODE_UNITS_W-1:0]   marker_units;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      // keep the log short, count everything
      if (failures < PRINT_LIMIT) begin
         $display("%0t: %s mismatch, got %h want %h", $time, what, got, want);
      end
      failures++;
   endtask

   function automatic void expect_char(input logic [CODE_POINT_W-1:0] cp,
                                       input logic [CODE_UNITS_W-1:0] units,
                                       input logic err, input logic last);
      decoded_char_type c;
      c.code_point  = cp;
      c.code_units  = units;
      c.error       = err;
      c.last_of_run = last;
      expected_chars.push_back(c);
   endfunction

   // or of 6-bit steps: lead minus its base, then each continuation minus 0x80
   function automatic logic [CODE_POINT_W-1:0] code_point_of(
      input logic [CODE_UNITS_W-1:0] units,
      input int                      len
   );
      logic [CODE_POINT_W-1:0] cp;
      logic [BYTE_W-1:0]       field;
      logic [BYTE_W-1:0]       lead_base;
      lead_base = (len == 4) ? LEAD4_BASE : (len == 3) ? LEAD3_BASE : LEAD2_BASE;
      field = units[8*(len-1) +: 8] - lead_base;
      cp = CODE_POINT_W'(field) << (6*(len-1));
      for (int i = 1; i < len; i++) begin
         field = units[8*(len-1-i) +: 8] - CONT_BASE;
         cp = cp | (CODE_POINT_W'(field) << (6*(len-1-i)));
      end
      return cp;
   endfunction

   task automatic decode_byte(input logic [BYTE_W-1:0] b);
      logic [CODE_UNITS_W-1:0] units;
      if (open_needed != 0) begin
         if (b >= CONT_BASE) begin
            units = {held, b};
            open_needed = open_needed - 1'b1;
            if (open_needed == 0) begin
               expect_char(code_point_of(units, int'(open_seen) + 1), units, 1'b0, 1'b1);
               held = '0;
               open_seen = '0;
               return;
            end
            held = units[HELD_W-1:0];
            open_seen = open_seen + 1'b1;
            return;
         end
         // byte below 0x80 drops the open sequence, then acts as a lead
         expect_char({10'd0, marker_cp}, marker_units, 1'b1, b == '0);
         held = '0;
         open_needed = '0;
         open_seen = '0;
      end
      if (b == '0) begin
         return;
      end
      if (b < CONT_BASE) begin
         expect_char({24'd0, b}, {24'd0, b}, 1'b0, 1'b1);
      end else if (b < LEAD2_BASE) begin
         expect_char({10'd0, marker_cp}, marker_units, 1'b1, 1'b1);
      end else begin
         open_needed = (b >= LEAD4_BASE) ? 2'd3 : (b >= LEAD3_BASE) ? 2'd2 : 2'd1;
         held = {16'd0, b};
         open_seen = 2'd1;
      end
   endtask

   task automatic check_char();
      decoded_char_type want;
      if (expected_chars.size() == 0) begin
         report_mismatch("unexpected result, code_point", rsp_code_point, '0);
         return;
      end
      want = expected_chars.pop_front();
      if (rsp_code_point !== want.code_point) begin
         report_mismatch("code_point", rsp_code_point, want.code_point);
      end
      if (rsp_code_units !== want.code_units) begin
         report_mismatch("code_units", rsp_code_units, want.code_units);
      end
      if (rsp_error !== want.error) begin
         report_mismatch("error", 32'(rsp_error), 32'(want.error));
      end
      if (rsp_last_of_run !== want.last_of_run) begin
         report_mismatch("last_of_run", 32'(rsp_last_of_run), 32'(want.last_of_run));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held         = '0;
         open_needed  = '0;
         open_seen    = '0;
         marker_cp    = INVALID_CP_RESET;
         marker_units = INVALID_UNITS_RESET;
         failures     = 0;
         expected_chars.delete();
      end else begin
         // results first so that a stray result cannot take a fresh expectation
         if (rsp_valid && !rsp_stall) begin
            check_char();
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_INVALID_CODE_POINT: marker_cp = csr_data[INVALID_CP_W-1:0];
               CSR_INVALID_UNITS:      marker_units = csr_data;
               default: begin
               end
            endcase
         end
         if (req_valid && !req_stall) begin
            decode_byte(req_byte_in);
         end
      end
      pending = expected_chars.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives byte streams and register writes into the utf-8 decoder: a directed
// run over the corner cases, then phases of mostly well-formed random text
// under different error markers and stall patterns; the checker predicts and
// compares, this module gives the verdict
// ----------------------------------------------------------------------------
module testbench;
   import usd_pkg::*;

   localparam int CLOCK_PERIOD    = 10;
   localparam int RESET_CYCLES    = 5;
   localparam int NUM_PHASES      = 5;
   localparam int ITEMS_PER_PHASE = 176;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 2000;  // well above the long hold-off

   // an index that maps to no register, writes to it must be ignored
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_INDEX = 8'd2;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [BYTE_W-1:0]        req_byte_in;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [CODE_POINT_W-1:0]  rsp_code_point;
   logic [CODE_UNITS_W-1:0]  rsp_code_units;
   logic                     rsp_error;
   logic                     rsp_last_of_run;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]    csr_data;

   int                       mismatch_total;
   int                       chars_pending;

   // stall knobs, percent chance of starting a burst
   int                       sender_idle_pct;
   int                       receiver_idle_pct;
   logic                     hold_off_req;
   int                       items_sent;
   int                       idle_cycles;
   logic [BYTE_W-1:0]        directed_bytes[$];

   utf8_stream_decoder u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_byte_in     (req_byte_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_code_units  (rsp_code_units),
      .rsp_error       (rsp_error),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   utf8_decode_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_byte_in     (req_byte_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_code_point  (rsp_code_point),
      .rsp_code_units  (rsp_code_units),
      .rsp_error       (rsp_error),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .failures        (mismatch_total),
      .pending         (chars_pending)
   );

   initial clock = 1'b0;
   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // one byte request: optional idle burst, then hold valid until taken;
   // entered and left at a falling edge
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      logic taken;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid   = 1'b1;
      req_byte_in = b;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !req_stall;
         if (!taken) begin
            @(negedge clock);
         end
      end
      if (b != '0) begin
         items_sent++;
      end
      @(negedge clock);
   endtask

   // leaves csr_valid high so that back-to-back writes need no toggle
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      logic taken;
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = data;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = csr_ready;
      end
      @(negedge clock);
   endtask

   // no byte in flight and every predicted character seen
   task automatic wait_drained();
      req_valid = 1'b0;
      while (chars_pending != 0) begin
         @(negedge clock);
      end
      // a lead or a zero byte may still be on its way through
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [BYTE_W-1:0] random_lead(input int len);
      case (len)
         2: return BYTE_W'($urandom_range(8'hC0, 8'hDF));
         3: return BYTE_W'($urandom_range(8'hE0, 8'hEF));
         default: return BYTE_W'($urandom_range(8'hF0, 8'hFF));
      endcase
   endfunction

   // one random piece of text, mostly well formed
   task automatic send_random_run();
      logic [BYTE_W-1:0] run_bytes[$];
      int                kind;
      int                len;
      kind = $urandom_range(0, 99);
      len  = $urandom_range(2, 4);
      if (kind < 25) begin
         run_bytes.push_back(BYTE_W'($urandom_range(1, 127)));
      end else if (kind < 70) begin
         // complete sequence with proper continuations
         run_bytes.push_back(random_lead(len));
         repeat (len - 1) run_bytes.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
      end else if (kind < 80) begin
         // sequence cut short by ascii or by the string terminator
         run_bytes.push_back(random_lead(len));
         repeat ($urandom_range(0, len - 2)) begin
            run_bytes.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
         end
         if ($urandom_range(0, 3) == 0) begin
            run_bytes.push_back('0);
         end else begin
            run_bytes.push_back(BYTE_W'($urandom_range(1, 127)));
         end
      end else if (kind < 85) begin
         // continuations from the whole upper half, 0xc0 and up included
         run_bytes.push_back(random_lead(len));
         repeat (len - 1) run_bytes.push_back(BYTE_W'($urandom_range(8'h80, 8'hFF)));
      end else if (kind < 90) begin
         run_bytes.push_back(BYTE_W'($urandom_range(8'h80, 8'hBF)));
      end else if (kind < 93) begin
         run_bytes.push_back('0);
      end else begin
         run_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
      end
      foreach (run_bytes[i]) begin
         send_byte(run_bytes[i]);
      end
   endtask

   // result side: random stall bursts, or one long hold-off on demand
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            rsp_stall = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
            rsp_stall    = 1'b0;
         end else if ($urandom_range(0, 99) < receiver_idle_pct) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clock);
            rsp_stall = 1'b0;
         end
      end
   end

   // watchdog: too long without any handshake ends the run
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("utf8_stream_decoder verification failed");
      $finish;
   end

   initial begin
      int items_target;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_byte_in       = '0;
      csr_valid         = 1'b0;
      csr_index         = CSR_INVALID_CODE_POINT;
      csr_data          = '0;
      hold_off_req      = 1'b0;
      sender_idle_pct   = 10;
      receiver_idle_pct = 10;
      items_sent        = 0;
      directed_bytes = '{
         8'h41, 8'h7F,                 // ascii, a letter and the highest ascii value
         8'h00,                        // terminator with nothing open
         8'hC0, 8'h80,                 // smallest two-byte form
         8'hDF, 8'hBF,                 // largest two-byte form
         8'hE2, 8'h82, 8'hAC,          // three-byte sequence
         8'hF0, 8'h9F, 8'h98, 8'h80,   // four-byte sequence
         8'hFF, 8'hFF, 8'hFF, 8'hFF,   // lead above 0xf7, continuations above 0xbf
         8'h80, 8'hBF,                 // stray continuations
         8'hE2, 8'h41,                 // sequence broken by ascii, two results
         8'hC3, 8'h00                  // sequence broken by the terminator
      };
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // corner cases under the reset markers
      foreach (directed_bytes[i]) begin
         send_byte(directed_bytes[i]);
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_drained();
         case (phase)
            0: begin
               write_csr(CSR_INVALID_CODE_POINT, '0);
               write_csr(CSR_INVALID_UNITS, '0);
               sender_idle_pct   = 30;
               receiver_idle_pct = 5;
            end
            1: begin
               // upper data bits past the 22-bit register must be dropped
               write_csr(CSR_INVALID_CODE_POINT, '1);
               write_csr(CSR_INVALID_UNITS, '1);
               sender_idle_pct   = 5;
               receiver_idle_pct = 30;
            end
            2: begin
               write_csr(CSR_INVALID_CODE_POINT, CSR_DATA_W'($urandom));
               write_csr(CSR_INVALID_UNITS, CSR_DATA_W'($urandom));
               sender_idle_pct   = 20;
               receiver_idle_pct = 20;
            end
            3: begin
               write_csr(CSR_UNMAPPED_INDEX, CSR_DATA_W'($urandom));
               write_csr(CSR_INVALID_UNITS, CSR_DATA_W'($urandom));
               // receiver holds off while bytes keep coming, so input backs up
               sender_idle_pct   = 0;
               receiver_idle_pct = 10;
               hold_off_req      = 1'b1;
            end
            default: begin
               // back to the reset markers, full rate to the end
               write_csr(CSR_INVALID_CODE_POINT, CSR_DATA_W'(INVALID_CP_RESET));
               write_csr(CSR_INVALID_UNITS, INVALID_UNITS_RESET);
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         csr_valid = 1'b0;
         items_target = items_sent + ITEMS_PER_PHASE;
         while (items_sent < items_target) begin
            send_random_run();
         end
      end

      wait_drained();
      if (mismatch_total == 0) begin
         $display("utf8_stream_decoder verification clean");
      end else begin
         $display("utf8_stream_decoder verification failed");
      end
      $finish;
   end

endmodule
